// File: sv/assert_macros.svh
// assertion macros used by the filter unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define AST_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication checked outside reset
`define AST_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// File: sv/oswf_pkg.sv
// shared types and constants of the order statistic window filter
package oswf_pkg;
	typedef enum logic [1:0] {
		MODE_MEDIAN   = 2'd0,
		MODE_MIDPOINT = 2'd1,
		MODE_TRIM     = 2'd2,
		MODE_SPARE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2,
		REG_TRIM   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATHER,
		ST_SORT,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	localparam int unsigned CMD_PIXEL = 0;
	localparam int unsigned CMD_DRAIN = 1;
	localparam logic [10:0] RST_WIDTH = 11'd640;
	localparam logic [10:0] RST_HEIGHT = 11'd480;
	localparam logic [2:0] RST_TRIM = 3'd2;
endpackage

// File: sv/oswf_divider.sv
// restoring divider, one quotient bit per cycle
module oswf_divider import oswf_pkg::*; #(
	parameter int NW = 18,
	parameter int DW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;

	always_comb begin
		trial = {r_q[DW-1:0], q_q[NW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	// done is registered on the last shift, so the quotient is complete while done is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule

// File: sv/order_statistic_window_filter_unit.sv
// order statistic window filter: line store, gather, sort, reduce
// steps: one store read per window pixel, odd-even sort passes, sum of the n-2d kept values, divide
// one item at a time: no new item is taken until the current one has finished
// pixel items with no result take a store write, then a registered compare
// the row store is one synchronous memory, one write and one read a cycle
// arst_n clears the counters and sets the configuration to 640, 480, median, trim 2
module order_statistic_window_filter_unit import oswf_pkg::*; #(
	parameter int WIN_W = 3,
	parameter int WIN_H = 3,
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] filtered,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
`include "assert_macros.svh"
	localparam int HW = WIN_W / 2;
	localparam int HH = WIN_H / 2;
	localparam int SW = 2 * HW + 1;
	localparam int SH = 2 * HH + 1;
	localparam int SLOTS = SH + 1;
	localparam int WMAX = SW * SH;
	localparam int XB = $clog2(MAX_WIDTH + 1);
	localparam int YB = $clog2(MAX_HEIGHT + 1);
	localparam int SB = $clog2(SLOTS);
	localparam int AB = $clog2(SLOTS * MAX_WIDTH);
	localparam int NB = $clog2(WMAX + 1);
	localparam int IB = XB + YB;
	localparam int SUMB = 8 + NB + 4;
	localparam int unsigned SREC = (65536 + SLOTS - 1) / SLOTS;

	// configuration registers
	logic [10:0] width_q, height_q;
	logic [1:0]  mode_q;
	logic [2:0]  trim_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			mode_q <= MODE_MEDIAN;
			trim_q <= RST_TRIM;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_MODE:   mode_q <= cfg_data[1:0];
				REG_TRIM:   trim_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// clamped geometry
	logic [XB-1:0] w;
	logic [YB-1:0] h;
	always_comb begin
		if (width_q == 11'd0) w = XB'(1);
		else if (32'(width_q) > MAX_WIDTH) w = XB'(MAX_WIDTH);
		else w = XB'(width_q);
		if (height_q == 11'd0) h = YB'(1);
		else if (32'(height_q) > MAX_HEIGHT) h = YB'(MAX_HEIGHT);
		else h = YB'(height_q);
	end

	// position counters
	logic [XB-1:0] in_col_q, out_col_q;
	logic [YB-1:0] in_row_q, out_row_q;
	logic [SB-1:0] in_slot_q;

	state_t st_q, st_d;
	logic [7:0] win_q [WMAX];
	logic [NB-1:0] n_q, cnt_q;
	logic [XB-1:0] x0_q, cw_q, gx_q;
	logic [YB-1:0] ch_q;
	logic [SB-1:0] gslot_q;
	logic rd_pend_q;
	logic [NB-1:0] pos_q;
	logic [SUMB-1:0] sum_q;
	logic [11:0] res_q;
	logic last_q, ov_q;
	logic chk_q;

	// row store
	logic [7:0] mem [SLOTS * MAX_WIDTH];
	logic [7:0] rdata_q;
	logic [AB-1:0] raddr;
	logic mem_we;
	logic [AB-1:0] waddr;
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= pixel;
		rdata_q <= mem[raddr];
	end
	assign waddr = AB'(32'(in_slot_q) * MAX_WIDTH + 32'(in_col_q));
	assign raddr = AB'(32'(gslot_q) * MAX_WIDTH + 32'(gx_q));

	logic accept;
	logic in_done;
	assign accept = in_valid && in_ready;
	assign in_done = in_row_q >= h;
	assign mem_we = accept && !cmd && !in_done && (32'(in_col_q) < MAX_WIDTH);

	// lag compare
	logic [IB-1:0] in_idx, out_idx, lag, hw_lim;
	logic [XB-1:0] ox;
	logic [YB-1:0] oy;
	assign in_idx = IB'(in_row_q) * IB'(w) + IB'(in_col_q);
	assign out_idx = IB'(out_row_q) * IB'(w) + IB'(out_col_q);
	assign hw_lim = (HW < 32'(w) - 1) ? IB'(HW) : IB'(w - 1'b1);
	assign lag = IB'(HH) * IB'(w) + hw_lim;
	assign ox = (out_col_q < w) ? out_col_q : w - 1'b1;
	assign oy = (out_row_q < h) ? out_row_q : h - 1'b1;

	logic go;
	assign go = chk_q ? (in_idx >= out_idx + lag + 1'b1) : (accept && cmd && in_done);

	logic [XB-1:0] x0, x1;
	logic [YB-1:0] y0, y1;
	always_comb begin
		x0 = (32'(ox) >= HW) ? ox - XB'(HW) : '0;
		y0 = (32'(oy) >= HH) ? oy - YB'(HH) : '0;
		x1 = (32'(ox) + HW < 32'(w)) ? ox + XB'(HW) : w - 1'b1;
		y1 = (32'(oy) + HH < 32'(h)) ? oy + YB'(HH) : h - 1'b1;
	end

	// store slot of the top window row, row mod slots by reciprocal multiply
	logic [31:0] y0_prod;
	logic [SB-1:0] y0_slot;
	always_comb begin
		y0_prod = 32'(y0) * SREC;
		y0_slot = SB'(32'(y0) - 32'(y0_prod[31:16]) * SLOTS);
	end

	// sort: odd-even transposition, one pass per cycle
	logic sort_odd_q;
	logic [NB-1:0] med_idx;
	logic [3:0] d2;
	logic [NB:0] keep;
	assign med_idx = NB'(32'(cw_q) / 2 + (32'(ch_q) / 2) * 32'(cw_q));
	assign d2 = {trim_q, 1'b0};
	assign keep = {1'b0, n_q} - (NB + 1)'(d2);

	// divider takes the trimmed sum with 4 fraction bits, so the quotient is 8.4
	logic div_start, div_done;
	logic [SUMB-1:0] quot;
	oswf_divider #(.NW(SUMB), .DW(NB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({sum_q[SUMB-5:0], 4'd0}), .den(keep[NB-1:0]), .done(div_done), .quot(quot)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:   if (go) st_d = ST_GATHER;
			ST_GATHER: if (rd_pend_q && cnt_q == n_q - 1'b1) st_d = ST_SORT;
			ST_SORT:   if (cnt_q == n_q) begin
				if (mode_q == MODE_TRIM && {1'b0, n_q} > (NB + 1)'(d2)) st_d = ST_SUM;
				else st_d = ST_OUT;
			end
			ST_SUM:    if (pos_q == n_q - NB'(trim_q)) st_d = ST_DIV;
			ST_DIV:    if (div_done) st_d = ST_OUT;
			ST_OUT:    if (out_ready && ov_q) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (st_q == ST_IDLE) && !chk_q;
		div_start = (st_q == ST_SUM) && (st_d == ST_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
			in_slot_q <= '0;
			chk_q <= 1'b0;
			ov_q <= 1'b0;
			rd_pend_q <= 1'b0;
			for (int i = 0; i < WMAX; i++) win_q[i] <= '0;
		end else begin
			st_q <= st_d;
			chk_q <= accept && !cmd && !in_done;
			if (accept && !cmd && !in_done) begin
				if (in_col_q + 1'b1 >= w) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
					in_slot_q <= (32'(in_slot_q) == SLOTS - 1) ? '0 : in_slot_q + 1'b1;
				end else in_col_q <= in_col_q + 1'b1;
			end
			case (st_q)
				ST_IDLE: if (go) begin
					x0_q <= x0;
					cw_q <= x1 - x0 + 1'b1; ch_q <= y1 - y0 + 1'b1;
					n_q <= NB'((x1 - x0 + 1'b1) * (y1 - y0 + 1'b1));
					gx_q <= x0;
					gslot_q <= y0_slot;
					cnt_q <= '0; rd_pend_q <= 1'b0;
					last_q <= (32'(out_idx) + 1 >= 32'(w) * 32'(h));
				end
				ST_GATHER: begin
					if (rd_pend_q) win_q[cnt_q] <= rdata_q;
					if (st_d == ST_SORT) begin
						cnt_q <= '0; sort_odd_q <= 1'b0; rd_pend_q <= 1'b0;
					end else begin
						rd_pend_q <= 1'b1;
						if (rd_pend_q) cnt_q <= cnt_q + 1'b1;
					end
					if (gx_q == x0_q + cw_q - 1'b1) begin
						gx_q <= x0_q;
						gslot_q <= (32'(gslot_q) == SLOTS - 1) ? '0 : gslot_q + 1'b1;
					end else gx_q <= gx_q + 1'b1;
				end
				ST_SORT: begin
					for (int i = 0; i + 1 < WMAX; i++) begin
						if ((i % 2) == int'(sort_odd_q) && i + 1 < int'(n_q)
							&& win_q[i] > win_q[i+1]) begin
							win_q[i] <= win_q[i+1];
							win_q[i+1] <= win_q[i];
						end
					end
					sort_odd_q <= !sort_odd_q;
					cnt_q <= cnt_q + 1'b1;
					pos_q <= NB'(trim_q);
					sum_q <= '0;
					case (mode_t'(mode_q))
						MODE_MIDPOINT: res_q <= 12'(({4'd0, win_q[0]} +
							{4'd0, win_q[n_q - 1'b1]}) * 12'd8);
						default: res_q <= {win_q[med_idx], 4'd0};
					endcase
					if (st_d == ST_OUT) ov_q <= 1'b1;
				end
				ST_SUM: if (st_d != ST_DIV) begin
					sum_q <= sum_q + SUMB'(win_q[pos_q]);
					pos_q <= pos_q + 1'b1;
				end
				ST_DIV: if (div_done) begin
					res_q <= quot[11:0];
					ov_q <= 1'b1;
				end
				ST_OUT: if (out_ready && ov_q) begin
					ov_q <= 1'b0;
					if (last_q) begin
						in_col_q <= '0; in_row_q <= '0;
						out_col_q <= '0; out_row_q <= '0; in_slot_q <= '0;
					end else if (out_col_q + 1'b1 >= w) begin
						out_col_q <= '0; out_row_q <= out_row_q + 1'b1;
					end else out_col_q <= out_col_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign filtered = res_q;
	assign frame_end = last_q;

	`AST_IMP(a_out_state, clk, arst_n, out_valid, st_q == ST_OUT)
	`AST_IMP(a_no_accept_busy, clk, arst_n, st_q != ST_IDLE, !in_ready)
	`AST_NXT(a_out_clears, clk, arst_n, out_valid && out_ready, !out_valid)
endmodule
